>>> rtl/bcc_pkg.sv
package bcc_pkg;

    // Default widths of the time base and of the click counter
    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 8;

    // Threshold registers
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 1;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_PRESS   = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CLICK_WINDOW = 1'd1;

    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET   = 16'd600;
    localparam logic [CFG_WIDTH-1:0] CLICK_WINDOW_RESET = 16'd400;

    typedef enum logic [2:0] {
        KIND_PRESS  = 3'd0,
        KIND_LONG   = 3'd1,
        KIND_DOUBLE = 3'd2,
        KIND_TRIPLE = 3'd3,
        KIND_MULTI  = 3'd4
    } t_kind;

    typedef struct packed {
        logic        pin_level;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        t_kind       event_kind;
        logic [31:0] press_length_ms;
        logic [7:0]  click_total;
    } t_out;

endpackage

>>> rtl/button_click_classifier.sv
// Channel | Direction | Handshake                | Beat payload
// --------+-----------+--------------------------+-----------------------------------
// in      | input     | i_in_valid / o_in_ready   | t_in  : pin_level, now_ms
// out     | output    | o_out_valid / i_out_ready | t_out : event_kind, press_length_ms,
//         |           |                          |         click_total
// cfg     | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// One sample per cycle sustained while no event is held back. A sample is
// captured in the input register and classified there; any event is then loaded
// into the output register, which offers it, once the sample advances.
// Reset (synchronous, active low) clears the press/click state and loads the
// default thresholds of 600 ms and 400 ms.
// A stalled output only holds back a sample that raises an event; samples that
// raise none keep draining, and the input register takes a new beat as soon as
// its current one advances.
module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in                      i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out                     o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_TWO = COUNT_BITS'(2);
    localparam logic [COUNT_BITS-1:0] COUNT_TRI = COUNT_BITS'(3);

    // Threshold registers
    logic [CFG_WIDTH-1:0] r_long_ms;
    logic [CFG_WIDTH-1:0] r_window_ms;

    // Input register
    logic r_in_valid;
    t_in  r_in;

    // Classifier state
    logic                  r_was_pressed, n_was_pressed;
    logic [TIME_BITS-1:0]  r_begin, n_begin;
    logic [TIME_BITS-1:0]  r_last_len, n_last_len;
    logic [COUNT_BITS-1:0] r_pending, n_pending;
    logic [TIME_BITS-1:0]  r_first, n_first;

    // Output register
    logic r_out_valid;
    t_out r_out;

    logic                  pressed;
    logic                  released;
    logic [TIME_BITS-1:0]  now_t;
    logic [TIME_BITS-1:0]  press_len;
    logic                  is_long;
    logic [COUNT_BITS-1:0] clicks;
    logic                  timed_out;
    logic                  has_event;
    t_out                  n_out;
    logic                  advance;

    // Retire the staged sample unless it raises an event that the full output
    // register cannot take yet.
    assign advance    = r_in_valid && (!has_event || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms   <= LONG_PRESS_RESET;
            r_window_ms <= CLICK_WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_PRESS:   r_long_ms   <= i_cfg_data;
                CFG_CLICK_WINDOW: r_window_ms <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Edge detect, classify a release, then check the click window, all with the
    // time of the same sample.
    always_comb begin
        pressed   = !r_in.pin_level;
        now_t     = TIME_BITS'(r_in.now_ms);
        released  = !pressed && r_was_pressed;
        press_len = now_t - r_begin;

        n_was_pressed = pressed;
        n_begin       = (pressed && !r_was_pressed) ? now_t : r_begin;
        n_last_len    = released ? press_len : r_last_len;
        is_long       = released && (press_len >= TIME_BITS'(r_long_ms));

        clicks = r_pending;
        if (released && !is_long && (r_pending != COUNT_MAX)) begin
            clicks = r_pending + COUNT_ONE;
        end
        n_first = r_first;
        if (released && !is_long && (clicks == COUNT_ONE)) begin
            n_first = now_t;
        end
        timed_out = !is_long && (clicks != '0)
                    && ((now_t - n_first) > TIME_BITS'(r_window_ms));

        has_event = is_long || timed_out;
        n_pending = has_event ? '0 : clicks;
    end

    // Build the event beat.
    always_comb begin
        n_out.event_kind      = KIND_PRESS;
        n_out.press_length_ms = '0;
        n_out.click_total     = '0;
        if (is_long) begin
            n_out.event_kind      = KIND_LONG;
            n_out.press_length_ms = 32'(n_last_len);
        end else begin
            case (clicks)
                COUNT_ONE: begin
                    n_out.event_kind      = KIND_PRESS;
                    n_out.press_length_ms = 32'(n_last_len);
                end
                COUNT_TWO: n_out.event_kind = KIND_DOUBLE;
                COUNT_TRI: n_out.event_kind = KIND_TRIPLE;
                default: begin
                    n_out.event_kind  = KIND_MULTI;
                    n_out.click_total = 8'(clicks);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_was_pressed <= 1'b0;
            r_begin       <= '0;
            r_last_len    <= '0;
            r_pending     <= '0;
            r_first       <= '0;
        end else begin
            // Input register: load on accept, drop once the beat advances.
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            // Advance the classifier state.
            if (advance) begin
                r_was_pressed <= n_was_pressed;
                r_begin       <= n_begin;
                r_last_len    <= n_last_len;
                r_pending     <= n_pending;
                r_first       <= n_first;
            end
            // Output register: load an event, drop a taken beat.
            if (advance && has_event) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance && has_event) begin
            r_out <= n_out;
        end
    end

    // An event always leaves no pending clicks behind.
    a_event_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && has_event |=> r_pending == '0)
        else $error("pending clicks survive an event");

    // A staged sample that cannot advance is held.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("staged sample lost while blocked");

    // The press state follows the sample that advanced.
    a_press_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_was_pressed == !$past(r_in.pin_level))
        else $error("press state does not follow the pin");

    // An event is never dropped while the output register is full.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("pending event overwritten");

endmodule
